/* sv/ftl_pkg.sv */
// Package for the flow table lookup with aging block: sizes, codes and types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ftl_pkg;
  localparam int TableDepth = 64;
  localparam int IdxBits = $clog2(TableDepth);
  localparam int PtrBits = IdxBits + 1;
  localparam int TimeBits = 48;
  localparam int ToBits = 48;
  localparam int KeyBits = 1 + 64 + 64 + 16 + 16;

  localparam logic [1:0] CmdLookup = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;

  localparam logic [2:0] StHit = 3'd0;
  localparam logic [2:0] StMiss = 3'd1;
  localparam logic [2:0] StInserted = 3'd2;
  localparam logic [2:0] StFull = 3'd3;
  localparam logic [2:0] StTick = 3'd4;

  localparam logic [PtrBits-1:0] Nil = PtrBits'(TableDepth);

  typedef struct packed {
    logic                load;
    logic                tick;
    logic                insert;
    logic                rd;
    logic [PtrBits-1:0]  rd_ptr;
    logic                hit;
    logic                expire;
  } ctrl_t;

  typedef struct packed {
    logic                full;
    logic [PtrBits-1:0]  head;
    logic [PtrBits-1:0]  next;
    logic                valid;
    logic                match;
    logic                old;
  } stat_t;
endpackage
`default_nettype wire

/* sv/ftl_ctrl.sv */
// Controller for the flow table: sequences insert, tick and the lookup walk.
// Depends on ftl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ftl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [1:0]    cmd_i,
  input  wire ftl_pkg::stat_t stat_i,
  output ftl_pkg::ctrl_t     ctrl_o,
  output logic               busy_o,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic               hit_o
);
  import ftl_pkg::*;

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SRead = 3'b010,
    SEval = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [PtrBits-1:0] cur_q, cur_d;
  logic [PtrBits-1:0] steps_q, steps_d;
  logic done_d;
  logic [2:0] status_d;
  logic hit_d;

  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    steps_d = steps_q;
    done_d = 1'b0;
    status_d = status_o;
    hit_d = 1'b0;
    ctrl_o = '0;
    ctrl_o.rd_ptr = cur_q;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          if (cmd_i[1]) begin
            ctrl_o.tick = 1'b1;
            done_d = 1'b1;
            status_d = StTick;
          end else if (cmd_i == CmdInsert) begin
            done_d = 1'b1;
            if (stat_i.full) begin
              status_d = StFull;
            end else begin
              ctrl_o.insert = 1'b1;
              status_d = StInserted;
            end
          end else begin
            cur_d = stat_i.head;
            steps_d = '0;
            state_d = SRead;
          end
        end
      end
      SRead: begin
        if (cur_q == Nil || steps_q == PtrBits'(TableDepth)) begin
          done_d = 1'b1;
          status_d = StMiss;
          state_d = SIdle;
        end else begin
          ctrl_o.rd = 1'b1;
          state_d = SEval;
        end
      end
      SEval: begin
        steps_d = steps_q + PtrBits'(1);
        if (!stat_i.valid) begin
          done_d = 1'b1;
          status_d = StMiss;
          state_d = SIdle;
        end else if (stat_i.match) begin
          ctrl_o.hit = 1'b1;
          done_d = 1'b1;
          hit_d = 1'b1;
          status_d = StHit;
          state_d = SIdle;
        end else begin
          ctrl_o.expire = stat_i.old;
          cur_d = stat_i.next;
          state_d = SRead;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cur_q <= Nil;
      steps_q <= '0;
      done_o <= 1'b0;
      status_o <= StMiss;
      hit_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      steps_q <= steps_d;
      done_o <= done_d;
      status_o <= status_d;
      hit_o <= hit_d;
    end
  end

  assign busy_o = (state_q != SIdle);
endmodule
`default_nettype wire

/* sv/ftl_dp.sv */
// Datapath for the flow table: entry memory, valid bits, chain links and time.
// Depends on ftl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ftl_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ftl_pkg::ctrl_t                ctrl_i,
  input  wire logic                          ip_version_i,
  input  wire logic [63:0]                   src_addr_hi_i,
  input  wire logic [63:0]                   src_addr_lo_i,
  input  wire logic [15:0]                   sport_i,
  input  wire logic [15:0]                   dport_i,
  input  wire logic [7:0]                    server_index_i,
  input  wire logic [ftl_pkg::ToBits-1:0]    timeout_i,
  output ftl_pkg::stat_t                     stat_o,
  output logic [7:0]                         server_o
);
  import ftl_pkg::*;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [7:0]         server;
  } entry_t;

  entry_t mem_q [TableDepth];
  logic [TimeBits-1:0] stamp_q [TableDepth];
  logic [PtrBits-1:0] next_q [TableDepth];
  logic [TableDepth-1:0] valid_q;
  logic [PtrBits-1:0] head_q;
  logic [TimeBits-1:0] now_q;
  logic [KeyBits-1:0] key_q, key_in;

  entry_t rd_q;
  logic [TimeBits-1:0] rd_stamp_q;
  logic [PtrBits-1:0] rd_next_q;
  logic rd_valid_q;
  logic [IdxBits-1:0] rd_idx_q;
  logic [PtrBits-1:0] prev_q;

  logic [IdxBits-1:0] free_idx;
  logic free_any;
  logic [TimeBits-1:0] idle;

  assign key_in = ip_version_i ?
      {1'b1, src_addr_hi_i, src_addr_lo_i, sport_i, dport_i} :
      {1'b0, 64'd0, 32'd0, src_addr_lo_i[31:0], sport_i, dport_i};

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxBits'(i);
        free_any = 1'b1;
      end
    end
  end

  assign idle = now_q - rd_stamp_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q <= key_in;
    end
    if (ctrl_i.insert) begin
      mem_q[free_idx] <= '{key: key_in, server: server_index_i};
      stamp_q[free_idx] <= now_q;
      next_q[free_idx] <= head_q;
    end
    if (ctrl_i.rd) begin
      rd_q <= mem_q[ctrl_i.rd_ptr[IdxBits-1:0]];
      rd_stamp_q <= stamp_q[ctrl_i.rd_ptr[IdxBits-1:0]];
      rd_next_q <= next_q[ctrl_i.rd_ptr[IdxBits-1:0]];
      rd_idx_q <= ctrl_i.rd_ptr[IdxBits-1:0];
    end
    if (ctrl_i.hit) begin
      stamp_q[rd_idx_q] <= now_q;
    end
    if (ctrl_i.expire && prev_q != Nil) begin
      next_q[prev_q[IdxBits-1:0]] <= rd_next_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      head_q <= Nil;
      now_q <= '0;
      rd_valid_q <= 1'b0;
      prev_q <= Nil;
    end else begin
      if (ctrl_i.tick) begin
        now_q <= now_q + TimeBits'(1);
      end
      if (ctrl_i.load) begin
        prev_q <= Nil;
      end
      if (ctrl_i.insert) begin
        valid_q[free_idx] <= 1'b1;
        head_q <= {1'b0, free_idx};
      end
      if (ctrl_i.rd) begin
        rd_valid_q <= valid_q[ctrl_i.rd_ptr[IdxBits-1:0]];
      end
      if (ctrl_i.expire) begin
        valid_q[rd_idx_q] <= 1'b0;
        if (prev_q == Nil) begin
          head_q <= rd_next_q;
        end
      end else if (stat_o.valid && !stat_o.match && !ctrl_i.load && !ctrl_i.rd) begin
        prev_q <= {1'b0, rd_idx_q};
      end
    end
  end

  assign stat_o.full = !free_any;
  assign stat_o.head = head_q;
  assign stat_o.next = rd_next_q;
  assign stat_o.valid = rd_valid_q;
  assign stat_o.match = (rd_q.key == key_q);
  assign stat_o.old = (TimeBits'(idle) > TimeBits'(timeout_i));
  assign server_o = rd_q.server;
endmodule
`default_nettype wire

/* sv/flow_table_lookup_with_aging.sv */
// Flow table lookup with aging. Tick and insert answer in the cycle after start.
// A lookup walks the chain one entry at a time, through a read state and an evaluate
// state with one memory read per entry; a miss walks up to 64 entries.
// busy is low in the result cycle, so a new transaction is taken at its end.
// Results cannot be stalled. Reset clears valid bits, chain head, time, timeout.
// Depends on ftl_pkg, ftl_ctrl and ftl_dp.
`timescale 1ns / 1ps
`default_nettype none
module flow_table_lookup_with_aging (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic        ip_version_i,
  input  wire logic [63:0] src_addr_hi_i,
  input  wire logic [63:0] src_addr_lo_i,
  input  wire logic [15:0] sport_i,
  input  wire logic [15:0] dport_i,
  input  wire logic [7:0]  server_index_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [7:0]       found_server_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import ftl_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic hit;
  logic [7:0] server;
  logic [ToBits-1:0] timeout_q;
  logic [0:0] waddr;

  assign waddr = paddr;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= '0;
    end else if (psel && penable && pwrite && waddr == 1'b0) begin
      timeout_q <= pwdata[ToBits-1:0];
    end
  end

  assign prdata = (paddr == 1'b0) ? {16'd0, timeout_q} : 64'd0;

  ftl_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .cmd_i,
    .stat_i(stat), .ctrl_o(ctrl), .busy_o, .done_o, .status_o, .hit_o(hit)
  );

  ftl_dp u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .ip_version_i, .src_addr_hi_i, .src_addr_lo_i,
    .sport_i, .dport_i, .server_index_i, .timeout_i(timeout_q),
    .stat_o(stat), .server_o(server)
  );

  assign found_server_o = hit ? server : 8'd0;

  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> done_o && status_o == StHit) else $error("hit without hit status");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.insert, ctrl.rd, ctrl.tick, ctrl.expire}))
    else $error("conflicting datapath commands");
endmodule
`default_nettype wire
